// ----- src/ae16_pkg.sv -----
package ae16_pkg;

  localparam int NUM_SYMBOLS = 257;
  localparam int CODE_WIDTH  = 16;
  localparam int PENDING_MAX = 255;
  localparam int MAX_RES     = 40;

  localparam int FREQ_W    = 16;
  localparam int TBL_DEPTH = NUM_SYMBOLS + 1;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int RANGE_W   = CODE_WIDTH + 1;
  localparam int DIVD_W    = RANGE_W + FREQ_W;
  localparam int DCNT_W    = $clog2(DIVD_W + 1);
  localparam int PEND_W    = $clog2(PENDING_MAX + 1);
  localparam int GUARD_MAX = 4 * CODE_WIDTH;
  localparam int GUARD_W   = $clog2(GUARD_MAX + 1);
  localparam int CNT_W     = $clog2(MAX_RES + 1);

  localparam logic [CODE_WIDTH-1:0] QTR_BIT = CODE_WIDTH'(1) << (CODE_WIDTH - 2);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    RD_PREV  = 2'd0,
    RD_CUR   = 2'd1,
    RD_TOTAL = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    item_start;
    logic    load;
    rd_sel_t rd_sel;
    logic    lat_prev;
    logic    lat_cur;
    logic    lat_total;
    logic    div_prev;
    logic    div_cur;
    logic    set_hi;
    logic    set_bounds;
    logic    renorm_send;
    logic    renorm_e3;
    logic    push_pend;
    logic    flush_inc;
    logic    flush_send;
    logic    tail;
    logic    finish;
    logic    coder_reset;
  } cmd_t;

  typedef struct packed {
    logic total_zero;
    logic div_busy;
    logic top_eq;
    logic e3;
    logic guard_done;
    logic pend_zero;
    logic push_ok;
    logic tail_ok;
    logic fin_ok;
  } status_t;

endpackage

// ----- src/ae16_div.sv -----
module ae16_div
  import ae16_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [FREQ_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [FREQ_W-1:0] rem;
  logic [DIVD_W-1:0] quo;
  logic [FREQ_W-1:0] dvsr;
  logic [DCNT_W-1:0] cnt;

  logic [FREQ_W:0]   shifted;
  logic [FREQ_W+1:0] trial;
  logic              ge;

  // Restoring division, one quotient bit per cycle, dividend shifted in MSB first.
  always_comb begin
    shifted = {rem, quo[DIVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr};
    ge      = !trial[FREQ_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DCNT_W'(DIVD_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? trial[FREQ_W-1:0] : shifted[FREQ_W-1:0];
      quo <= {quo[DIVD_W-2:0], ge};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

// ----- src/ae16_dp.sv -----
module ae16_dp
  import ae16_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  logic [TBL_AW-1:0] entry_index,
  input  logic [FREQ_W-1:0] entry_value,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              last,
  output logic              overflow
);

  logic [FREQ_W-1:0] mem [TBL_DEPTH];
  logic [FREQ_W-1:0] rdata;
  logic [TBL_AW-1:0] rd_addr;

  logic [7:0]            byte_r;
  logic [FREQ_W-1:0]     c_prev;
  logic [FREQ_W-1:0]     c_cur;
  logic [FREQ_W-1:0]     total_r;
  logic [RANGE_W-1:0]    range_r;
  logic [CODE_WIDTH-1:0] hi_tmp;
  logic [CODE_WIDTH-1:0] low;
  logic [CODE_WIDTH-1:0] high;
  logic [PEND_W-1:0]     pending;
  logic [GUARD_W-1:0]    guard;
  logic                  bit_val;
  logic [7:0]            bit_buf;
  logic [2:0]            held;
  logic                  ovf_flag;
  logic [CNT_W-1:0]      byte_cnt;
  logic                  hold_full;
  logic [7:0]            hold_byte;

  logic                  div_start;
  logic [DIVD_W-1:0]     dividend;
  logic                  div_busy;
  logic [DIVD_W-1:0]     quotient;

  logic                  push_en;
  logic                  pbit;
  logic [7:0]            buf_shift;
  logic [7:0]            tail_byte;
  logic                  cap_ok;
  logic                  byte_done;
  logic                  enter;
  logic [7:0]            enter_byte;
  logic                  move;
  logic                  out_busy;
  logic                  pend_inc;
  logic [CODE_WIDTH-1:0] low_x;
  logic [CODE_WIDTH-1:0] high_x;

  // Cumulative table: one write port for loads, one registered read port.
  always_comb begin
    case (cmd.rd_sel)
      RD_PREV:  rd_addr = TBL_AW'(data_byte);
      RD_CUR:   rd_addr = TBL_AW'(byte_r) + 1'b1;
      RD_TOTAL: rd_addr = '0;
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (entry_index <= TBL_AW'(NUM_SYMBOLS))) begin
      mem[entry_index] <= entry_value;
    end
    rdata <= mem[rd_addr];
  end

  assign div_start = cmd.div_prev | cmd.div_cur;
  assign dividend  = DIVD_W'(range_r) * DIVD_W'(cmd.div_prev ? c_prev : c_cur);

  ae16_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (total_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.item_start) begin
      byte_r <= data_byte;
    end
    if (cmd.lat_prev) begin
      c_prev  <= rdata;
      // The difference wraps at the code width before the increment.
      range_r <= {1'b0, high - low} + RANGE_W'(1);
    end
    if (cmd.lat_cur) begin
      c_cur <= rdata;
    end
    if (cmd.lat_total) begin
      total_r <= rdata;
    end
    if (cmd.set_hi) begin
      hi_tmp <= low + quotient[CODE_WIDTH-1:0] - 1'b1;
    end
    if (cmd.renorm_send || cmd.flush_send) begin
      bit_val <= pbit;
    end
    if (enter) begin
      hold_byte <= enter_byte;
    end
    if (move) begin
      out_byte <= hold_byte;
      last     <= cmd.finish;
      overflow <= ovf_flag;
    end
  end

  // Bit packer: the newest code bit enters at the top, so the first lands in bit zero.
  always_comb begin
    if (cmd.renorm_send) begin
      pbit = low[CODE_WIDTH-1];
    end else if (cmd.flush_send) begin
      pbit = (low >= QTR_BIT);
    end else begin
      pbit = ~bit_val;
    end
    push_en    = cmd.renorm_send | cmd.flush_send | cmd.push_pend;
    buf_shift  = {pbit, bit_buf[7:1]};
    tail_byte  = (held == 3'd0) ? 8'd0 : (bit_buf >> (4'd8 - {1'b0, held}));
    cap_ok     = (byte_cnt != CNT_W'(MAX_RES));
    byte_done  = push_en && (held == 3'd7);
    enter      = (byte_done || cmd.tail) && cap_ok;
    enter_byte = cmd.tail ? tail_byte : buf_shift;
    move       = hold_full && (enter || cmd.finish);
    out_busy   = out_valid && out_stall;
    pend_inc   = cmd.renorm_e3 || cmd.flush_inc;
    low_x      = cmd.renorm_e3 ? (low ^ QTR_BIT) : low;
    high_x     = cmd.renorm_e3 ? (high ^ QTR_BIT) : high;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.coder_reset) begin
      low      <= '0;
      high     <= '1;
      pending  <= '0;
      bit_buf  <= '0;
      held     <= '0;
      ovf_flag <= 1'b0;
      guard    <= '0;
    end else begin
      if (cmd.set_bounds) begin
        low   <= low + quotient[CODE_WIDTH-1:0];
        high  <= hi_tmp;
        guard <= '0;
      end else if (cmd.renorm_send || cmd.renorm_e3) begin
        low   <= low_x << 1;
        high  <= (high_x << 1) | CODE_WIDTH'(1);
        guard <= guard + 1'b1;
      end
      if (pend_inc) begin
        if (pending != PEND_W'(PENDING_MAX)) begin
          pending <= pending + 1'b1;
        end else begin
          ovf_flag <= 1'b1;
        end
      end else if (cmd.push_pend) begin
        pending <= pending - 1'b1;
      end
      if (push_en) begin
        if (held == 3'd7) begin
          bit_buf <= '0;
          held    <= '0;
        end else begin
          bit_buf <= buf_shift;
          held    <= held + 1'b1;
        end
      end
    end
  end

  // One byte waits in the hold register until the item shows whether it is the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
      out_valid <= 1'b0;
      byte_cnt  <= '0;
    end else begin
      if (cmd.item_start) begin
        byte_cnt <= '0;
      end else if (enter) begin
        byte_cnt <= byte_cnt + 1'b1;
      end
      if (enter) begin
        hold_full <= 1'b1;
      end else if (cmd.finish) begin
        hold_full <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    st.total_zero = (rdata == '0);
    st.div_busy   = div_busy;
    st.top_eq     = (low[CODE_WIDTH-1] == high[CODE_WIDTH-1]);
    st.e3         = low[CODE_WIDTH-2] && !high[CODE_WIDTH-2];
    st.guard_done = (guard == GUARD_W'(GUARD_MAX));
    st.pend_zero  = (pending == '0);
    st.push_ok    = !((held == 3'd7) && cap_ok && hold_full && out_busy);
    st.tail_ok    = !(cap_ok && hold_full && out_busy);
    st.fin_ok     = !(hold_full && out_busy);
  end

  a_push_unblocked: assert property (@(posedge clk) disable iff (rst)
    (cmd.renorm_send || cmd.flush_send || cmd.push_pend) |-> st.push_ok)
    else $error("bit pushed while the byte path is blocked");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    byte_cnt <= CNT_W'(MAX_RES))
    else $error("byte count beyond the per-item limit");

  a_finish_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && st.fin_ok) |=> !hold_full)
    else $error("hold register not drained at end of item");

  a_coder_reset: assert property (@(posedge clk) disable iff (rst)
    cmd.coder_reset |=> (low == '0) && (high == '1) && (pending == '0) && (held == '0))
    else $error("coder state not cleared after flush");

endmodule

// ----- src/ae16_ctrl.sv -----
module ae16_ctrl
  import ae16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] op,
  output logic       in_stall,
  output cmd_t       cmd,
  input  status_t    st
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_RD1     = 12'b0000_0000_0010,
    S_RD2     = 12'b0000_0000_0100,
    S_RD3     = 12'b0000_0000_1000,
    S_MUL1    = 12'b0000_0001_0000,
    S_DIV1    = 12'b0000_0010_0000,
    S_DIV2    = 12'b0000_0100_0000,
    S_RENORM  = 12'b0000_1000_0000,
    S_PEND    = 12'b0001_0000_0000,
    S_FL_SEND = 12'b0010_0000_0000,
    S_FL_TAIL = 12'b0100_0000_0000,
    S_FIN     = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   flushing;
  logic   flushing_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    flushing_next = flushing;
    cmd           = '0;
    cmd.rd_sel    = RD_PREV;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_start = 1'b1;
          case (op_t'(op))
            OP_LOAD: begin
              cmd.load = 1'b1;
            end
            OP_ENCODE: begin
              cmd.rd_sel    = RD_PREV;
              flushing_next = 1'b0;
              state_next    = S_RD1;
            end
            OP_FLUSH: begin
              cmd.flush_inc = 1'b1;
              flushing_next = 1'b1;
              state_next    = S_FL_SEND;
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        cmd.lat_prev = 1'b1;
        cmd.rd_sel   = RD_CUR;
        state_next   = S_RD2;
      end
      S_RD2: begin
        cmd.lat_cur = 1'b1;
        cmd.rd_sel  = RD_TOTAL;
        state_next  = S_RD3;
      end
      S_RD3: begin
        // A zero total leaves the coder untouched and yields no bytes.
        cmd.lat_total = 1'b1;
        state_next    = st.total_zero ? S_IDLE : S_MUL1;
      end
      S_MUL1: begin
        cmd.div_prev = 1'b1;
        state_next   = S_DIV1;
      end
      S_DIV1: begin
        if (!st.div_busy) begin
          cmd.set_hi  = 1'b1;
          cmd.div_cur = 1'b1;
          state_next  = S_DIV2;
        end
      end
      S_DIV2: begin
        if (!st.div_busy) begin
          cmd.set_bounds = 1'b1;
          state_next     = S_RENORM;
        end
      end
      S_RENORM: begin
        if (st.guard_done) begin
          state_next = S_FIN;
        end else if (st.top_eq) begin
          if (st.push_ok) begin
            cmd.renorm_send = 1'b1;
            state_next      = S_PEND;
          end
        end else if (st.e3) begin
          cmd.renorm_e3 = 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_PEND: begin
        if (st.pend_zero) begin
          state_next = flushing ? S_FL_TAIL : S_RENORM;
        end else if (st.push_ok) begin
          cmd.push_pend = 1'b1;
        end
      end
      S_FL_SEND: begin
        if (st.push_ok) begin
          cmd.flush_send = 1'b1;
          state_next     = S_PEND;
        end
      end
      S_FL_TAIL: begin
        if (st.tail_ok) begin
          cmd.tail   = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.fin_ok) begin
          cmd.finish      = 1'b1;
          cmd.coder_reset = flushing;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      flushing <= 1'b0;
    end else begin
      state    <= state_next;
      flushing <= flushing_next;
    end
  end

endmodule

// ----- src/arithmetic_encoder_16bit.sv -----
// 16-bit arithmetic encoder with a static cumulative-frequency table. The block takes
// one item at a time. An encode takes three table reads, a multiply state and two
// 33-step serial divides, then the renormalization shifts and the emitted code bits,
// one at a time; both divides share the single bit-serial divider. A flush emits its
// final bit, the pending bits after it and a tail byte. Bytes leave through a one-byte
// hold register and an output register; a stalled output holds the coder when another
// byte is due.
module arithmetic_encoder_16bit
  import ae16_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [7:0]        data_byte,
  input  logic [TBL_AW-1:0] entry_index,
  input  logic [FREQ_W-1:0] entry_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              last,
  output logic              overflow
);

  cmd_t    cmd;
  status_t st;

  ae16_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  ae16_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .cmd         (cmd),
    .st          (st),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last        (last),
    .overflow    (overflow)
  );

endmodule

// ----- tb/arithmetic_encoder_16bit_test.sv -----
`timescale 1ns / 1ps

module arithmetic_encoder_16bit_test
  import ae16_pkg::*;
();

  localparam int TOTAL_BEATS    = 430;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 400;
  localparam int MAX_REPORTS    = 10;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [7:0] code;
    logic       fin;
    logic       ovf;
  } code_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          op = OP_LOAD;
  logic [7:0]          data_byte = '0;
  logic [TBL_AW-1:0]   entry_index = '0;
  logic [FREQ_W-1:0]   entry_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                last;
  logic                overflow;

  arithmetic_encoder_16bit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .data_byte   (data_byte),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last        (last),
    .overflow    (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Coder state as the encoder should hold it.
  logic [CODE_WIDTH-1:0] lo_q = '0;
  logic [CODE_WIDTH-1:0] hi_q = '1;
  int unsigned           pend_q = 0;
  logic [7:0]            code_acc = '0;
  int unsigned           acc_bits = 0;
  logic                  ovf_q = 1'b0;
  logic [FREQ_W-1:0]     freq_tbl [0:TBL_DEPTH-1];
  bit                    written [0:TBL_DEPTH-1];
  logic [7:0]            item_bytes [$];

  code_beat_t due_bytes [$];
  code_beat_t want;

  int  errors = 0;
  int  beats_sent = 0;
  int  n_loads = 0, n_encodes = 0, n_flushes = 0, n_spares = 0;
  int  bytes_checked = 0, ovf_bytes = 0;
  int  burst_left = 0;
  bit  send_idle = 1'b0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  function automatic void clear_coder();
    lo_q = '0;
    hi_q = '1;
    pend_q = 0;
    code_acc = '0;
    acc_bits = 0;
    ovf_q = 1'b0;
  endfunction

  function automatic void bump_pending();
    if (pend_q < PENDING_MAX) pend_q++;
    else ovf_q = 1'b1;
  endfunction

  // Code bits enter at the top, so the first bit ends up in bit zero.
  function automatic void shift_in_bit(logic b);
    code_acc = {b, code_acc[7:1]};
    acc_bits++;
    if (acc_bits >= 8) begin
      if (item_bytes.size() < MAX_RES) item_bytes.push_back(code_acc);
      acc_bits = 0;
      code_acc = '0;
    end
  endfunction

  function automatic void emit_bit(logic b);
    shift_in_bit(b);
    while (pend_q > 0) begin
      shift_in_bit(~b);
      pend_q--;
    end
  endfunction

  function automatic void narrow_interval(int sym);
    logic [63:0] total, span, upper, lower;
    total = freq_tbl[0];
    if (total == 0 || sym > NUM_SYMBOLS) return;
    span  = {48'd0, hi_q - lo_q} + 64'd1;
    upper = {48'd0, lo_q} + (span * freq_tbl[sym-1]) / total - 64'd1;
    lower = {48'd0, lo_q} + (span * freq_tbl[sym]) / total;
    hi_q = upper[CODE_WIDTH-1:0];
    lo_q = lower[CODE_WIDTH-1:0];
    for (int g = 0; g < GUARD_MAX; g++) begin
      if (hi_q[CODE_WIDTH-1] == lo_q[CODE_WIDTH-1]) begin
        emit_bit(lo_q[CODE_WIDTH-1]);
      end else if (lo_q[CODE_WIDTH-2] && !hi_q[CODE_WIDTH-2]) begin
        // Interval straddles the middle: defer the bit and expand around it.
        bump_pending();
        lo_q[CODE_WIDTH-2] = ~lo_q[CODE_WIDTH-2];
        hi_q[CODE_WIDTH-2] = ~hi_q[CODE_WIDTH-2];
      end else begin
        break;
      end
      lo_q = lo_q << 1;
      hi_q = {hi_q[CODE_WIDTH-2:0], 1'b1};
    end
  endfunction

  function automatic void finish_stream();
    bump_pending();
    emit_bit(lo_q < QTR_BIT ? 1'b0 : 1'b1);
    if (item_bytes.size() < MAX_RES)
      item_bytes.push_back(acc_bits == 0 ? 8'd0 : code_acc >> (8 - acc_bits));
  endfunction

  function automatic void predict_beat(logic [1:0] o, logic [7:0] b,
                                       logic [TBL_AW-1:0] ix, logic [FREQ_W-1:0] v);
    logic       sticky;
    code_beat_t beat;
    item_bytes.delete();
    if (o == OP_LOAD) begin
      n_loads++;
      if (ix <= NUM_SYMBOLS) begin
        freq_tbl[ix] = v;
        written[ix] = 1'b1;
      end
      return;
    end
    if (o == OP_ENCODE) begin
      n_encodes++;
      narrow_interval(int'(b) + 1);
      sticky = ovf_q;
    end else if (o == OP_FLUSH) begin
      n_flushes++;
      finish_stream();
      sticky = ovf_q;
      clear_coder();
    end else begin
      n_spares++;
      return;
    end
    for (int k = 0; k < item_bytes.size(); k++) begin
      beat.code = item_bytes[k];
      beat.fin  = (k == item_bytes.size() - 1);
      beat.ovf  = sticky;
      due_bytes.push_back(beat);
    end
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(logic [1:0] o, logic [7:0] b,
                           logic [TBL_AW-1:0] ix, logic [FREQ_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    op          <= o;
    data_byte   <= b;
    entry_index <= ix;
    entry_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    predict_beat(o, b, ix, v);
  endtask

  task automatic load_entry(int ix, logic [FREQ_W-1:0] v);
    send_beat(OP_LOAD, 8'($urandom), TBL_AW'(ix), v);
  endtask

  task automatic encode_beat(int b);
    send_beat(OP_ENCODE, 8'(b), TBL_AW'($urandom), FREQ_W'($urandom));
  endtask

  task automatic flush_beat();
    send_beat(OP_FLUSH, 8'($urandom), TBL_AW'($urandom), FREQ_W'($urandom));
  endtask

  task automatic spare_beat();
    send_beat(OP_SPARE, 8'($urandom), TBL_AW'($urandom), FREQ_W'($urandom));
  endtask

  // Descending cumulative curve from total at entry 0 to zero at the top entry,
  // strictly so from a total of NUM_SYMBOLS up; smaller totals give zero-width symbols.
  function automatic logic [FREQ_W-1:0] curve_value(int shape, longint unsigned total_f,
                                                    int ix);
    longint unsigned rest, scale;
    rest = NUM_SYMBOLS - ix;
    if (total_f <= NUM_SYMBOLS) return FREQ_W'((total_f * rest) / NUM_SYMBOLS);
    scale = total_f - NUM_SYMBOLS;
    if (shape == 0) return FREQ_W'(scale * rest / NUM_SYMBOLS + rest);
    return FREQ_W'(scale * rest * rest / (NUM_SYMBOLS * NUM_SYMBOLS) + rest);
  endfunction

  task automatic test_directed();
    stall_pct = 0;
    send_idle = 1'b0;
    load_entry(511, 16'hffff);   // index beyond the table is dropped
    load_entry(NUM_SYMBOLS + 1, 16'h0000);
    load_entry(0, 16'h0000);
    load_entry(1, 16'h1234);
    encode_beat(0);              // zero total: nothing coded
    spare_beat();
    flush_beat();                // flush of an untouched coder
    load_entry(0, 16'hffff);
    load_entry(1, 16'hc000);
    load_entry(2, 16'h8000);
    load_entry(3, 16'h9000);     // above entry 2, so symbol 3 is inverted
    load_entry(255, 16'h0100);
    load_entry(256, 16'h0000);
    load_entry(NUM_SYMBOLS, 16'h0000);
    encode_beat(0);
    encode_beat(1);
    encode_beat(255);
    encode_beat(255);
    flush_beat();
    encode_beat(2);
    flush_beat();
  endtask

  // A narrow symbol centered on one half keeps the coder in middle scaling, so
  // the deferred-bit count runs into its ceiling.
  task automatic test_pending_saturation();
    stall_pct = 30;
    send_idle = 1'b1;
    load_entry(0, 16'd1024);
    load_entry(1, 16'd513);
    load_entry(2, 16'd511);
    load_entry(3, 16'd0);
    for (int k = 0; k < 32; k++) encode_beat(1);
    flush_beat();
    encode_beat(0);
    flush_beat();
  endtask

  // A rare symbol yields about a byte per encode; the receiver holds off
  // meanwhile so the output side fills and the input stalls.
  task automatic test_output_backpressure();
    stall_pct = 0;
    send_idle = 1'b0;
    load_entry(0, 16'hffff);
    load_entry(1, 16'hff00);
    load_entry(2, 16'h0000);
    hold_req = 1'b1;
    for (int k = 0; k < 24; k++) begin
      if (k % 6 == 5) flush_beat();
      else encode_beat(0);
    end
  endtask

  task automatic test_random_tables();
    longint unsigned total_f;
    int shape, n_runs, s, len, n_items, r, b, start;
    int run_bytes [$];
    while (beats_sent < TOTAL_BEATS) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      send_idle = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0:       total_f = $urandom_range(2, NUM_SYMBOLS);
        1, 2:    total_f = 16'hffff;
        3, 4:    total_f = $urandom_range(NUM_SYMBOLS + 1, 2000);
        default: total_f = $urandom_range(NUM_SYMBOLS + 1, 65535);
      endcase
      shape = $urandom_range(0, 1);
      run_bytes.delete();
      load_entry(0, curve_value(shape, total_f, 0));
      // Write a few short runs of the curve; only symbols with both ends
      // written in this set are encoded from it.
      n_runs = $urandom_range(2, 5);
      for (int j = 0; j < n_runs; j++) begin
        s = $urandom_range(0, 255);
        len = $urandom_range(1, 5);
        for (int ix = s; ix <= s + len && ix <= NUM_SYMBOLS; ix++)
          load_entry(ix, curve_value(shape, total_f, ix));
        for (int ix = s + 1; ix <= s + len && ix <= 256; ix++)
          run_bytes.push_back(ix - 1);
      end
      n_items = $urandom_range(20, 45);
      for (int k = 0; k < n_items && beats_sent < TOTAL_BEATS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          encode_beat(run_bytes[$urandom_range(0, run_bytes.size() - 1)]);
        end else if (r < 87) begin
          flush_beat();
        end else if (r < 90) begin
          spare_beat();
        end else if (r < 94) begin
          load_entry($urandom_range(NUM_SYMBOLS + 1, 511), FREQ_W'($urandom));
        end else if (r < 97) begin
          // Any symbol whose entries hold something, stale or not.
          b = -1;
          start = $urandom_range(0, 255);
          for (int j = 0; j < 256 && b < 0; j++) begin
            if (written[0] && written[(start + j) % 256] && written[(start + j) % 256 + 1])
              b = (start + j) % 256;
          end
          if (b >= 0) encode_beat(b);
        end else begin
          load_entry($urandom_range(0, NUM_SYMBOLS), FREQ_W'($urandom));
        end
      end
      flush_beat();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      bytes_checked++;
      if (due_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected code byte %02h last=%0b overflow=%0b",
                   out_byte, last, overflow);
      end else begin
        want = due_bytes.pop_front();
        if (want.ovf) ovf_bytes++;
        if (out_byte !== want.code || last !== want.fin || overflow !== want.ovf) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"code byte %0d: expected %02h last=%0b overflow=%0b, ",
                      "got %02h last=%0b overflow=%0b"},
                     bytes_checked, want.code, want.fin, want.ovf, out_byte, last, overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no beat moved on either side for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    clear_coder();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pending_saturation();
    test_output_backpressure();
    test_random_tables();
    in_valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d beats: %0d table loads, %0d encodes, %0d flushes, %0d unused ops",
             beats_sent, n_loads, n_encodes, n_flushes, n_spares);
    $display("checked %0d code bytes, %0d of them with the overflow flag set",
             bytes_checked, ovf_bytes);
    if (errors == 0 && due_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d code bytes never arrived", errors, due_bytes.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
